[sv/assert_macros.svh]
// Assertion helpers for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[sv/rwca_pkg.sv]
package rwca_pkg;

  localparam int unsigned DigitW      = 7;
  localparam int unsigned DigitCount  = 5;
  localparam int unsigned DigitMax    = 99;
  localparam int unsigned SeqW        = 34;
  localparam int unsigned LenW        = 11;
  localparam int unsigned BytesW      = 17;
  localparam int unsigned RelW        = 7;
  localparam int unsigned SlotW       = 6;
  localparam int unsigned WindowDef   = 64;
  localparam int unsigned MaxPayloadDef = 1280;

  typedef enum logic [1:0] {
    ACT_DELIVER = 2'd0,
    ACT_BUFFER  = 2'd1,
    ACT_OLD     = 2'd2,
    ACT_BEYOND  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEQ,
    S_CLASS,
    S_RELEASE,
    S_OUT
  } rw_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HORNER
  } sq_phase_e;

  typedef struct packed {
    logic [DigitW-1:0] seq_digit_0;
    logic [DigitW-1:0] seq_digit_1;
    logic [DigitW-1:0] seq_digit_2;
    logic [DigitW-1:0] seq_digit_3;
    logic [DigitW-1:0] seq_digit_4;
    logic [LenW-1:0]   payload_length;
  } in_item_t;

  typedef struct packed {
    action_e           action;
    logic [SlotW-1:0]  slot_index;
    logic [SeqW-1:0]   ack_number;
    logic [DigitW-1:0] ack_digit_0;
    logic [DigitW-1:0] ack_digit_1;
    logic [DigitW-1:0] ack_digit_2;
    logic [DigitW-1:0] ack_digit_3;
    logic [DigitW-1:0] ack_digit_4;
    logic [RelW-1:0]   released_count;
    logic [BytesW-1:0] delivered_bytes;
  } out_item_t;

  typedef logic [DigitCount-1:0][DigitW-1:0] digits_t;

  // Control from the sequencer to one window cell.
  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

  // Adds one to a base-100 number held as digits, wrapping the top digit.
  function automatic digits_t digits_inc(digits_t d);
    digits_t r;
    logic    carry;
    r     = d;
    carry = 1'b1;
    for (int i = 0; i < DigitCount; i++) begin
      if (carry) begin
        if (d[i] == DigitW'(DigitMax)) begin
          r[i] = '0;
        end else begin
          r[i]  = d[i] + DigitW'(1);
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

[sv/reorder_window_cumulative_ack_top.sv]
// Receiver window with cumulative acknowledgement.
// Input channel: one packet header per transfer (five base-100 sequence
// digits and a payload length), moved by in_valid_i / in_stall_o.
// Output channel: one result per header (action, slot, acknowledgement as
// a number and as digits, released count, delivered bytes), moved by
// out_valid_o / out_stall_i.
// Steps after a header is accepted: the sequence number is formed, the
// header is classified, a delivery walks the released run through the cell
// chain (one shift per cycle), and the result is loaded into the output
// register. A new header is taken only once the previous result has been
// loaded into the output register. WINDOW must be a power of two.
// The window is a chain of WINDOW cells, cell k holding the packet with
// sequence number ack + 1 + k; releasing shifts the chain by one cell.
// Reset clears the acknowledgement and all presence bits at once; stored
// lengths are not cleared. A stalled result holds in the output register;
// the next header is still taken and waits in the final step until the
// output register frees up.
`include "assert_macros.svh"

module reorder_window_cumulative_ack_top #(
  parameter int unsigned WINDOW      = rwca_pkg::WindowDef,
  parameter int unsigned MAX_PAYLOAD = rwca_pkg::MaxPayloadDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rwca_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rwca_pkg::out_item_t out_data_o
);

  localparam int unsigned RemW = $clog2(WINDOW);
  localparam int unsigned RcW  = $clog2(WINDOW + 1);
  localparam int unsigned SeqW = rwca_pkg::SeqW;
  localparam int unsigned LenW = rwca_pkg::LenW;

  rwca_pkg::rw_state_e          state_q, state_d;
  logic [SeqW-1:0]              ack_q, ack_d;
  rwca_pkg::digits_t            ackdig_q, ackdig_d;
  logic [LenW-1:0]              len_q, len_d;
  rwca_pkg::action_e            act_q, act_d;
  logic [RemW-1:0]              slot_q, slot_d;
  logic [RcW-1:0]               rel_q, rel_d;
  logic [rwca_pkg::BytesW-1:0]  bytes_q, bytes_d;
  logic                         out_valid_q;
  rwca_pkg::out_item_t          out_q;
  logic                         out_load;

  logic                         seq_start;
  logic                         seq_done;
  logic [SeqW-1:0]              seq;
  logic [RemW-1:0]              rem;
  rwca_pkg::digits_t            in_digits;

  logic [SeqW:0]                diff;
  logic [RemW-1:0]              wr_idx;
  logic                         shift;
  logic                         buf_wr;
  logic [WINDOW-1:0]            pres_vec;
  logic [LenW-1:0]              cell_len [WINDOW];

  logic                         out_not_delivered;
  logic                         out_carries_none;

  assign in_digits = {in_data_i.seq_digit_4, in_data_i.seq_digit_3,
                      in_data_i.seq_digit_2, in_data_i.seq_digit_1,
                      in_data_i.seq_digit_0};

  rwca_seq_unit #(
    .WINDOW (WINDOW)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (seq_start),
    .digits_i (in_digits),
    .done_o   (seq_done),
    .seq_o    (seq),
    .rem_o    (rem)
  );

  // Window cells; the last one takes an empty entry on a shift.
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    rwca_pkg::cell_ctrl_t ctrl;
    logic                 nxt_present;
    logic [LenW-1:0]      nxt_len;
    assign ctrl.shift = shift;
    assign ctrl.wr    = buf_wr && (wr_idx == RemW'(k));
    if (k == WINDOW - 1) begin : g_last
      assign nxt_present = 1'b0;
      assign nxt_len     = '0;
    end else begin : g_mid
      assign nxt_present = pres_vec[k+1];
      assign nxt_len     = cell_len[k+1];
    end
    rwca_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .wr_len_i       (len_q),
      .next_present_i (nxt_present),
      .next_len_i     (nxt_len),
      .present_o      (pres_vec[k]),
      .len_o          (cell_len[k])
    );
  end

  assign diff   = {1'b0, seq} - {1'b0, ack_q};
  assign wr_idx = RemW'(diff - (SeqW + 1)'(1));

  assign in_stall_o = (state_q != rwca_pkg::S_IDLE);

  // Sequencer: classify the header, then walk the released run.
  always_comb begin
    state_d   = state_q;
    ack_d     = ack_q;
    ackdig_d  = ackdig_q;
    len_d     = len_q;
    act_d     = act_q;
    slot_d    = slot_q;
    rel_d     = rel_q;
    bytes_d   = bytes_q;
    seq_start = 1'b0;
    shift     = 1'b0;
    buf_wr    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      rwca_pkg::S_IDLE: begin
        if (in_valid_i) begin
          seq_start = 1'b1;
          if ({5'b0, in_data_i.payload_length} > 16'(MAX_PAYLOAD)) begin
            len_d = LenW'(MAX_PAYLOAD);
          end else begin
            len_d = in_data_i.payload_length;
          end
          state_d = rwca_pkg::S_SEQ;
        end
      end
      rwca_pkg::S_SEQ: begin
        if (seq_done) begin
          state_d = rwca_pkg::S_CLASS;
        end
      end
      rwca_pkg::S_CLASS: begin
        slot_d  = rem;
        rel_d   = '0;
        bytes_d = '0;
        state_d = rwca_pkg::S_OUT;
        priority if (diff == (SeqW + 1)'(1)) begin
          act_d    = rwca_pkg::ACT_DELIVER;
          ack_d    = ack_q + SeqW'(1);
          ackdig_d = rwca_pkg::digits_inc(ackdig_q);
          bytes_d  = rwca_pkg::BytesW'(len_q);
          shift    = 1'b1;
          state_d  = rwca_pkg::S_RELEASE;
        end else if (diff[SeqW] || (diff == '0)) begin
          act_d = rwca_pkg::ACT_OLD;
        end else if (diff[SeqW-1:0] > SeqW'(WINDOW)) begin
          act_d = rwca_pkg::ACT_BEYOND;
        end else if (pres_vec[wr_idx]) begin
          act_d = rwca_pkg::ACT_OLD;
        end else begin
          act_d  = rwca_pkg::ACT_BUFFER;
          buf_wr = 1'b1;
        end
      end
      rwca_pkg::S_RELEASE: begin
        if (pres_vec[0]) begin
          bytes_d  = bytes_q + rwca_pkg::BytesW'(cell_len[0]);
          ack_d    = ack_q + SeqW'(1);
          ackdig_d = rwca_pkg::digits_inc(ackdig_q);
          rel_d    = rel_q + RcW'(1);
          shift    = 1'b1;
        end else begin
          state_d = rwca_pkg::S_OUT;
        end
      end
      rwca_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = rwca_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rwca_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rwca_pkg::S_IDLE;
      ack_q       <= '0;
      ackdig_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ack_q    <= ack_d;
      ackdig_q <= ackdig_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and the output register.
  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    act_q   <= act_d;
    slot_q  <= slot_d;
    rel_q   <= rel_d;
    bytes_q <= bytes_d;
    if (out_load) begin
      out_q.action          <= act_q;
      out_q.slot_index      <= rwca_pkg::SlotW'(slot_q);
      out_q.ack_number      <= ack_q;
      out_q.ack_digit_0     <= ackdig_q[0];
      out_q.ack_digit_1     <= ackdig_q[1];
      out_q.ack_digit_2     <= ackdig_q[2];
      out_q.ack_digit_3     <= ackdig_q[3];
      out_q.ack_digit_4     <= ackdig_q[4];
      out_q.released_count  <= rwca_pkg::RelW'(rel_q);
      out_q.delivered_bytes <= bytes_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Terms for the delivery check on the output register.
  assign out_not_delivered = out_valid_o && (out_q.action != rwca_pkg::ACT_DELIVER);
  assign out_carries_none  = (out_q.released_count == '0) && (out_q.delivered_bytes == '0);

  // Cell zero stands for ack + 1, which is only ever present mid-release.
  `ASSERT_IMPL(a_head_empty, clk_i, rst_ni, state_q != rwca_pkg::S_RELEASE, !pres_vec[0])
  // A dropped or buffered header carries no delivery.
  `ASSERT_IMPL(a_no_bytes, clk_i, rst_ni, out_not_delivered, out_carries_none)
  // The arithmetic unit finishes only while the sequencer waits for it.
  `ASSERT_IMPL(a_seq_done, clk_i, rst_ni, seq_done, state_q == rwca_pkg::S_SEQ)
  // A taken header always starts the sequence number pass.
  `ASSERT_NEXT(a_start, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == rwca_pkg::S_SEQ)

endmodule

[sv/rwca_cell.sv]
module rwca_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rwca_pkg::cell_ctrl_t       ctrl_i,
  input  logic [rwca_pkg::LenW-1:0]  wr_len_i,
  input  logic                       next_present_i,
  input  logic [rwca_pkg::LenW-1:0]  next_len_i,
  output logic                       present_o,
  output logic [rwca_pkg::LenW-1:0]  len_o
);

  logic                      present_q, present_d;
  logic [rwca_pkg::LenW-1:0] len_q, len_d;

  // A shift takes the neighbor's entry; a write marks a buffered packet.
  always_comb begin
    present_d = present_q;
    len_d     = len_q;
    priority if (ctrl_i.shift) begin
      present_d = next_present_i;
      len_d     = next_len_i;
    end else if (ctrl_i.wr) begin
      present_d = 1'b1;
      len_d     = wr_len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
    end else begin
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  assign present_o = present_q;
  assign len_o     = len_q;

endmodule

[sv/rwca_seq_unit.sv]
module rwca_seq_unit #(
  parameter int unsigned WINDOW = rwca_pkg::WindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  rwca_pkg::digits_t             digits_i,
  output logic                          done_o,
  output logic [rwca_pkg::SeqW-1:0]     seq_o,
  output logic [$clog2(WINDOW)-1:0]     rem_o
);

  localparam int unsigned RemW = $clog2(WINDOW);
  localparam int unsigned CntW = $clog2(rwca_pkg::DigitCount);

  rwca_pkg::sq_phase_e           phase_q, phase_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  rwca_pkg::digits_t             dig_q, dig_d;
  logic [rwca_pkg::SeqW-1:0]     seq_q, seq_d;
  logic [rwca_pkg::DigitW-1:0]   digit;
  logic [CntW-1:0]               dig_idx;

  assign dig_idx = CntW'(rwca_pkg::DigitCount - 1) - cnt_q;
  assign digit   = dig_q[dig_idx];

  // Horner pass over the digits, most significant first; done is raised
  // in the last pass cycle, so the number is ready in the next cycle.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    dig_d   = dig_q;
    seq_d   = seq_q;
    done_o  = 1'b0;
    unique case (phase_q)
      rwca_pkg::PH_IDLE: begin
        if (start_i) begin
          dig_d   = digits_i;
          seq_d   = '0;
          cnt_d   = '0;
          phase_d = rwca_pkg::PH_HORNER;
        end
      end
      rwca_pkg::PH_HORNER: begin
        seq_d = (seq_q << 6) + (seq_q << 5) + (seq_q << 2)
              + rwca_pkg::SeqW'(digit);
        if (cnt_q == CntW'(rwca_pkg::DigitCount - 1)) begin
          done_o  = 1'b1;
          cnt_d   = '0;
          phase_d = rwca_pkg::PH_IDLE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: begin
        phase_d = rwca_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rwca_pkg::PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    seq_q <= seq_d;
  end

  assign seq_o = seq_q;
  // The user must keep the window size a power of two (not checked here), so the slot is the low bits.
  assign rem_o = seq_q[RemW-1:0];

endmodule
